@@ rtl/qwvs_pkg.sv @@
// Shared types, widths and codes for the quaternion weighted vertex skinning block.
package qwvs_pkg;

    localparam int POS_W     = 32;  // joint position, offset, Q16.16
    localparam int Q_W       = 16;  // quaternion part, Q1.15
    localparam int BIAS_W    = 17;  // bias, unsigned Q1.16
    localparam int OUT_W     = 32;  // vertex field
    localparam int ACC_W     = 40;  // running sum
    localparam int Q_FRAC    = 15;
    localparam int BIAS_FRAC = 16;

    // intermediate widths sized to the worst case of the fixed-point chain
    localparam int T_W    = 35;     // q * p, rounded
    localparam int R_W    = 36;     // t * conj(q), rounded
    localparam int V_W    = 37;     // joint + r
    localparam int C_W    = 38;     // (joint + r) * bias, rounded
    localparam int OPA_W  = 38;     // multiplier operand A
    localparam int OPB_W  = 18;     // multiplier operand B (signed q or bias)
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int LANES  = 4;

    typedef struct packed {
        logic signed [POS_W-1:0] joint_pos_x;
        logic signed [POS_W-1:0] joint_pos_y;
        logic signed [POS_W-1:0] joint_pos_z;
        logic signed [Q_W-1:0]   orient_x;
        logic signed [Q_W-1:0]   orient_y;
        logic signed [Q_W-1:0]   orient_z;
        logic signed [Q_W-1:0]   orient_w;
        logic signed [POS_W-1:0] offset_x;
        logic signed [POS_W-1:0] offset_y;
        logic signed [POS_W-1:0] offset_z;
        logic        [BIAS_W-1:0] bias;
        logic                    last_weight;
    } t_in_item;

    // multiplier lane operations
    typedef enum logic [3:0] {
        MOP_NONE,
        MOP_TW,
        MOP_TX,
        MOP_TY,
        MOP_TZ,
        MOP_RX,
        MOP_RY,
        MOP_RZ,
        MOP_BIAS
    } t_mop;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TW,
        ST_TX,
        ST_TY,
        ST_TZ,
        ST_WAIT_T,
        ST_RX,
        ST_RY,
        ST_RZ,
        ST_WAIT_R,
        ST_ADD_J,
        ST_MUL_B,
        ST_RND_B,
        ST_ACC,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        t_mop mul_op;
        logic add_j;
        logic acc;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic out_busy;
    } t_dp_sts;

endpackage

@@ rtl/qwvs_if.sv @@
// Valid/ready channel interfaces for weight items and skinned vertices.
interface qwvs_in_if;
    import qwvs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  joint_pos_x;
    logic signed [POS_W-1:0]  joint_pos_y;
    logic signed [POS_W-1:0]  joint_pos_z;
    logic signed [Q_W-1:0]    orient_x;
    logic signed [Q_W-1:0]    orient_y;
    logic signed [Q_W-1:0]    orient_z;
    logic signed [Q_W-1:0]    orient_w;
    logic signed [POS_W-1:0]  offset_x;
    logic signed [POS_W-1:0]  offset_y;
    logic signed [POS_W-1:0]  offset_z;
    logic        [BIAS_W-1:0] bias;
    logic                     last_weight;

    modport source (
        output valid, joint_pos_x, joint_pos_y, joint_pos_z,
               orient_x, orient_y, orient_z, orient_w,
               offset_x, offset_y, offset_z, bias, last_weight,
        input  ready
    );
    modport sink (
        input  valid, joint_pos_x, joint_pos_y, joint_pos_z,
               orient_x, orient_y, orient_z, orient_w,
               offset_x, offset_y, offset_z, bias, last_weight,
        output ready
    );
endinterface

interface qwvs_out_if;
    import qwvs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] vertex_x;
    logic signed [OUT_W-1:0] vertex_y;
    logic signed [OUT_W-1:0] vertex_z;

    modport source (output valid, vertex_x, vertex_y, vertex_z, input ready);
    modport sink   (input valid, vertex_x, vertex_y, vertex_z, output ready);
endinterface

@@ rtl/quaternion_weighted_vertex_skinning.sv @@
// Top level of the quaternion weighted vertex skinning block.
//
//  channel   direction  payload                                    handshake
//  i_in      in         joint pos, orientation, offset, bias, last   valid/ready
//  o_out     out        vertex_x/y/z, saturated Q16.16               valid/ready
//
// A weight is accepted once the previous one has stepped through ST_TW to ST_ACC,
// and a last weight also through ST_EMIT; the four shared multiplier lanes and
// their rounding sum stage serve both quaternion products and the bias scaling.
// A finished vertex sits in the output register; if it is still stalled when the
// next vertex completes, the block holds before emitting.
// Synchronous active-low reset clears the sequencer, the running sum and o_out.valid.
module quaternion_weighted_vertex_skinning
    import qwvs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    qwvs_in_if.sink    i_in,
    qwvs_out_if.source o_out
);

    t_dp_cmd  w_cmd;
    t_dp_sts  w_sts;
    t_in_item w_item;
    logic     w_in_ready;

    assign w_item.joint_pos_x = i_in.joint_pos_x;
    assign w_item.joint_pos_y = i_in.joint_pos_y;
    assign w_item.joint_pos_z = i_in.joint_pos_z;
    assign w_item.orient_x    = i_in.orient_x;
    assign w_item.orient_y    = i_in.orient_y;
    assign w_item.orient_z    = i_in.orient_z;
    assign w_item.orient_w    = i_in.orient_w;
    assign w_item.offset_x    = i_in.offset_x;
    assign w_item.offset_y    = i_in.offset_y;
    assign w_item.offset_z    = i_in.offset_z;
    assign w_item.bias        = i_in.bias;
    assign w_item.last_weight = i_in.last_weight;

    assign i_in.ready = w_in_ready;

    qwvs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    qwvs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_vertex_x  (o_out.vertex_x),
        .o_vertex_y  (o_out.vertex_y),
        .o_vertex_z  (o_out.vertex_z)
    );

endmodule

@@ rtl/qwvs_ctrl.sv @@
// Sequencer that steps the skinning datapath through one weight transaction.
module qwvs_ctrl
    import qwvs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.mul_op = MOP_NONE;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_TW;
                end
            end
            ST_TW: begin
                o_cmd.mul_op = MOP_TW;
                n_state      = ST_TX;
            end
            ST_TX: begin
                o_cmd.mul_op = MOP_TX;
                n_state      = ST_TY;
            end
            ST_TY: begin
                o_cmd.mul_op = MOP_TY;
                n_state      = ST_TZ;
            end
            ST_TZ: begin
                o_cmd.mul_op = MOP_TZ;
                n_state      = ST_WAIT_T;
            end
            // t_z is summed this cycle; rotation products need all of t
            ST_WAIT_T: begin
                n_state = ST_RX;
            end
            ST_RX: begin
                o_cmd.mul_op = MOP_RX;
                n_state      = ST_RY;
            end
            ST_RY: begin
                o_cmd.mul_op = MOP_RY;
                n_state      = ST_RZ;
            end
            ST_RZ: begin
                o_cmd.mul_op = MOP_RZ;
                n_state      = ST_WAIT_R;
            end
            ST_WAIT_R: begin
                n_state = ST_ADD_J;
            end
            ST_ADD_J: begin
                o_cmd.add_j = 1'b1;
                n_state     = ST_MUL_B;
            end
            ST_MUL_B: begin
                o_cmd.mul_op = MOP_BIAS;
                n_state      = ST_RND_B;
            end
            ST_RND_B: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_sts.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                // hold until the output register is free or draining
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/qwvs_dp.sv @@
// Datapath: four shared multiplier lanes, rounding sum stage, accumulator and output register.
module qwvs_dp
    import qwvs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_in_item                i_item,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic signed [OUT_W-1:0] o_vertex_x,
    output logic signed [OUT_W-1:0] o_vertex_y,
    output logic signed [OUT_W-1:0] o_vertex_z
);

    localparam logic signed [SUM_W-1:0]  RND_Q = SUM_W'(2 ** (Q_FRAC - 1));
    localparam logic signed [PROD_W-1:0] RND_B = PROD_W'(2 ** (BIAS_FRAC - 1));

    function automatic logic signed [ACC_W-1:0] f_acc_sat(
        input logic signed [ACC_W:0] v
    );
        logic signed [ACC_W-1:0] res;
        res = v[ACC_W-1:0];
        if (v[ACC_W] != v[ACC_W-1]) begin
            res = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return res;
    endfunction

    function automatic logic signed [OUT_W-1:0] f_out_sat(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [OUT_W-1:0] res;
        res = v[OUT_W-1:0];
        if (!((&v[ACC_W-1:OUT_W-1]) || !(|v[ACC_W-1:OUT_W-1]))) begin
            res = v[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end
        return res;
    endfunction

    // captured transaction
    logic signed [POS_W-1:0]  r_jx, r_jy, r_jz;
    logic signed [POS_W-1:0]  r_px, r_py, r_pz;
    logic signed [Q_W-1:0]    r_qx, r_qy, r_qz, r_qw;
    logic        [BIAS_W-1:0] r_bias;
    logic                     r_last;

    // intermediate results
    logic signed [T_W-1:0]    r_tw, r_tx, r_ty, r_tz;
    logic signed [R_W-1:0]    r_rx, r_ry, r_rz;
    logic signed [V_W-1:0]    r_vx, r_vy, r_vz;
    logic signed [C_W-1:0]    r_c [3];
    logic signed [ACC_W-1:0]  r_sum_x, r_sum_y, r_sum_z;

    logic signed [PROD_W-1:0] r_prod [LANES];
    t_mop                     r_mop_d;

    logic                     r_out_valid;
    logic signed [OUT_W-1:0]  r_vertex_x, r_vertex_y, r_vertex_z;

    logic signed [OPA_W-1:0]  w_a [LANES];
    logic signed [OPB_W-1:0]  w_b [LANES];
    logic signed [OPB_W-1:0]  w_qx, w_qy, w_qz, w_qw, w_bias;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [SUM_W-1:0]  w_sum_rnd;
    logic signed [PROD_W-1:0] w_c_rnd [3];

    assign w_qx   = OPB_W'(r_qx);
    assign w_qy   = OPB_W'(r_qy);
    assign w_qz   = OPB_W'(r_qz);
    assign w_qw   = OPB_W'(r_qw);
    assign w_bias = $signed({1'b0, r_bias});

    // lane operands; signs of the quaternion terms ride on operand B
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w_a[i] = '0;
            w_b[i] = '0;
        end
        case (i_cmd.mul_op)
            MOP_TW: begin
                w_a[0] = OPA_W'(r_px); w_b[0] = -w_qx;
                w_a[1] = OPA_W'(r_py); w_b[1] = -w_qy;
                w_a[2] = OPA_W'(r_pz); w_b[2] = -w_qz;
            end
            MOP_TX: begin
                w_a[0] = OPA_W'(r_px); w_b[0] = w_qw;
                w_a[1] = OPA_W'(r_pz); w_b[1] = w_qy;
                w_a[2] = OPA_W'(r_py); w_b[2] = -w_qz;
            end
            MOP_TY: begin
                w_a[0] = OPA_W'(r_py); w_b[0] = w_qw;
                w_a[1] = OPA_W'(r_pz); w_b[1] = -w_qx;
                w_a[2] = OPA_W'(r_px); w_b[2] = w_qz;
            end
            MOP_TZ: begin
                w_a[0] = OPA_W'(r_pz); w_b[0] = w_qw;
                w_a[1] = OPA_W'(r_py); w_b[1] = w_qx;
                w_a[2] = OPA_W'(r_px); w_b[2] = -w_qy;
            end
            MOP_RX: begin
                w_a[0] = OPA_W'(r_tw); w_b[0] = -w_qx;
                w_a[1] = OPA_W'(r_tx); w_b[1] = w_qw;
                w_a[2] = OPA_W'(r_ty); w_b[2] = -w_qz;
                w_a[3] = OPA_W'(r_tz); w_b[3] = w_qy;
            end
            MOP_RY: begin
                w_a[0] = OPA_W'(r_tw); w_b[0] = -w_qy;
                w_a[1] = OPA_W'(r_tx); w_b[1] = w_qz;
                w_a[2] = OPA_W'(r_ty); w_b[2] = w_qw;
                w_a[3] = OPA_W'(r_tz); w_b[3] = -w_qx;
            end
            MOP_RZ: begin
                w_a[0] = OPA_W'(r_tw); w_b[0] = -w_qz;
                w_a[1] = OPA_W'(r_tx); w_b[1] = -w_qy;
                w_a[2] = OPA_W'(r_ty); w_b[2] = w_qx;
                w_a[3] = OPA_W'(r_tz); w_b[3] = w_qw;
            end
            MOP_BIAS: begin
                w_a[0] = OPA_W'(r_vx); w_b[0] = w_bias;
                w_a[1] = OPA_W'(r_vy); w_b[1] = w_bias;
                w_a[2] = OPA_W'(r_vz); w_b[2] = w_bias;
            end
            default: begin
            end
        endcase
    end

    // sum stage: dot product of the lanes, rounded half up
    always_comb begin
        w_sum = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1])
              + SUM_W'(r_prod[2]) + SUM_W'(r_prod[3]);
        w_sum_rnd = (w_sum + RND_Q) >>> Q_FRAC;
        for (int i = 0; i < 3; i++) begin
            w_c_rnd[i] = (r_prod[i] + RND_B) >>> BIAS_FRAC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mop_d <= MOP_NONE;
        end else begin
            r_mop_d <= i_cmd.mul_op;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LANES; i++) begin
            r_prod[i] <= w_a[i] * w_b[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_jx   <= i_item.joint_pos_x;
            r_jy   <= i_item.joint_pos_y;
            r_jz   <= i_item.joint_pos_z;
            r_px   <= i_item.offset_x;
            r_py   <= i_item.offset_y;
            r_pz   <= i_item.offset_z;
            r_qx   <= i_item.orient_x;
            r_qy   <= i_item.orient_y;
            r_qz   <= i_item.orient_z;
            r_qw   <= i_item.orient_w;
            r_bias <= i_item.bias;
            r_last <= i_item.last_weight;
        end
        case (r_mop_d)
            MOP_TW:   r_tw <= T_W'(w_sum_rnd);
            MOP_TX:   r_tx <= T_W'(w_sum_rnd);
            MOP_TY:   r_ty <= T_W'(w_sum_rnd);
            MOP_TZ:   r_tz <= T_W'(w_sum_rnd);
            MOP_RX:   r_rx <= R_W'(w_sum_rnd);
            MOP_RY:   r_ry <= R_W'(w_sum_rnd);
            MOP_RZ:   r_rz <= R_W'(w_sum_rnd);
            MOP_BIAS: begin
                for (int i = 0; i < 3; i++) begin
                    r_c[i] <= C_W'(w_c_rnd[i]);
                end
            end
            default: begin
            end
        endcase
        if (i_cmd.add_j) begin
            r_vx <= V_W'(r_jx) + V_W'(r_rx);
            r_vy <= V_W'(r_jy) + V_W'(r_ry);
            r_vz <= V_W'(r_jz) + V_W'(r_rz);
        end
        if (i_cmd.emit) begin
            r_vertex_x <= f_out_sat(r_sum_x);
            r_vertex_y <= f_out_sat(r_sum_y);
            r_vertex_z <= f_out_sat(r_sum_z);
        end
    end

    // running vertex sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_sum_z <= '0;
        end else if (i_cmd.emit) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_sum_z <= '0;
        end else if (i_cmd.acc) begin
            r_sum_x <= f_acc_sat((ACC_W + 1)'(r_sum_x) + (ACC_W + 1)'(r_c[0]));
            r_sum_y <= f_acc_sat((ACC_W + 1)'(r_sum_y) + (ACC_W + 1)'(r_c[1]));
            r_sum_z <= f_acc_sat((ACC_W + 1)'(r_sum_z) + (ACC_W + 1)'(r_c[2]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_vertex_x  = r_vertex_x;
    assign o_vertex_y  = r_vertex_y;
    assign o_vertex_z  = r_vertex_z;

endmodule

@@ rtl/qwvs_checker.sv @@
// Port-level checks for the skinning block, bound to its top level.
module qwvs_checker
    import qwvs_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [OUT_W-1:0] i_vertex_x,
    input logic signed [OUT_W-1:0] i_vertex_y,
    input logic signed [OUT_W-1:0] i_vertex_z
);

    // one weight at a time: ready drops right after a transaction
    a_in_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted on consecutive cycles");

    // a vertex never shows up the cycle right after reset
    a_no_out_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("output valid right after reset");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_out_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_vertex_x) && $stable(i_vertex_y) && $stable(i_vertex_z)))
        else $error("output payload changed while stalled");

endmodule

bind quaternion_weighted_vertex_skinning qwvs_checker u_qwvs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_vertex_x  (o_out.vertex_x),
    .i_vertex_y  (o_out.vertex_y),
    .i_vertex_z  (o_out.vertex_z)
);

@@ tb/testbench.sv @@
// Testbench for the quaternion weighted vertex skinning block: predicted vertices vs. o_out.
`timescale 1ns / 1ps

module testbench;
    import qwvs_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int WEIGHT_ITEMS = 1650;
    localparam logic signed [POS_W-1:0] ONE = 32'sh0001_0000;
    localparam logic signed [Q_W-1:0] Q_ONE = 16'sh7fff;
    localparam logic [BIAS_W-1:0] BIAS_ONE = 17'd65536;
    localparam logic [BIAS_W-1:0] BIAS_MAX = 17'h1ffff;

    typedef struct {
        t_in_item    w;
        int unsigned gap;
        bit          drain;
    } t_weight_txn;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
    } t_vertex;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    qwvs_in_if  in_ch ();
    qwvs_out_if out_ch ();

    quaternion_weighted_vertex_skinning i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // driven state, known from time zero
    logic     drv_valid = 1'b0;
    t_in_item drv_w = '0;
    logic     sink_ready = 1'b0;

    assign in_ch.valid       = drv_valid;
    assign in_ch.joint_pos_x = drv_w.joint_pos_x;
    assign in_ch.joint_pos_y = drv_w.joint_pos_y;
    assign in_ch.joint_pos_z = drv_w.joint_pos_z;
    assign in_ch.orient_x    = drv_w.orient_x;
    assign in_ch.orient_y    = drv_w.orient_y;
    assign in_ch.orient_z    = drv_w.orient_z;
    assign in_ch.orient_w    = drv_w.orient_w;
    assign in_ch.offset_x    = drv_w.offset_x;
    assign in_ch.offset_y    = drv_w.offset_y;
    assign in_ch.offset_z    = drv_w.offset_z;
    assign in_ch.bias        = drv_w.bias;
    assign in_ch.last_weight = drv_w.last_weight;
    assign out_ch.ready      = sink_ready;

    t_weight_txn weight_q[$];
    t_vertex     vertex_q[$];

    longint      acc_x = 0;
    longint      acc_y = 0;
    longint      acc_z = 0;
    int unsigned idle_cycles = 0;
    int unsigned n_total = 0;
    int unsigned n_taken = 0;
    int unsigned stall_left = 0;
    int unsigned vertices_seen = 0;
    int unsigned quiet_cycles = 0;
    int          errors = 0;
    bit          calm = 1'b0;
    bit          no_stall = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // floor((v + 2^(n-1)) / 2^n)
    function automatic longint round_q(input longint v, input int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp_s(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // rotate, translate, scale by bias and accumulate; a last weight yields a vertex
    function automatic void skin_weight(input t_in_item w);
        longint jx, jy, jz, qx, qy, qz, qw, px, py, pz, b;
        longint tw, tx, ty, tz, rx, ry, rz;
        t_vertex v;
        jx = longint'(w.joint_pos_x);
        jy = longint'(w.joint_pos_y);
        jz = longint'(w.joint_pos_z);
        qx = longint'(w.orient_x);
        qy = longint'(w.orient_y);
        qz = longint'(w.orient_z);
        qw = longint'(w.orient_w);
        px = longint'(w.offset_x);
        py = longint'(w.offset_y);
        pz = longint'(w.offset_z);
        b  = longint'(w.bias);

        tw = round_q(-qx * px - qy * py - qz * pz, Q_FRAC);
        tx = round_q(qw * px + qy * pz - qz * py, Q_FRAC);
        ty = round_q(qw * py - qx * pz + qz * px, Q_FRAC);
        tz = round_q(qw * pz + qx * py - qy * px, Q_FRAC);

        rx = round_q(-tw * qx + tx * qw - ty * qz + tz * qy, Q_FRAC);
        ry = round_q(-tw * qy + tx * qz + ty * qw - tz * qx, Q_FRAC);
        rz = round_q(-tw * qz - tx * qy + ty * qx + tz * qw, Q_FRAC);

        acc_x = clamp_s(acc_x + round_q((jx + rx) * b, BIAS_FRAC), ACC_W);
        acc_y = clamp_s(acc_y + round_q((jy + ry) * b, BIAS_FRAC), ACC_W);
        acc_z = clamp_s(acc_z + round_q((jz + rz) * b, BIAS_FRAC), ACC_W);

        if (w.last_weight) begin
            v.x = OUT_W'(clamp_s(acc_x, OUT_W));
            v.y = OUT_W'(clamp_s(acc_y, OUT_W));
            v.z = OUT_W'(clamp_s(acc_z, OUT_W));
            vertex_q.push_back(v);
            acc_x = 0;
            acc_y = 0;
            acc_z = 0;
        end
    endfunction

    function automatic void add_weight(input t_in_item w, input bit drain);
        t_weight_txn t;
        t.w     = w;
        t.gap   = calm ? 0 : $urandom_range(0, 12);
        t.drain = drain;
        weight_q.push_back(t);
    endfunction

    function automatic logic signed [POS_W-1:0] pos_val(input bit wild);
        case ($urandom_range(0, 11))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return '0;
            default: begin
                if (wild) return $urandom;
                return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic signed [OUT_W-1:0] want,
                                        input logic signed [OUT_W-1:0] got);
        if (got !== want) begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // sender: one transaction at a time, gap drawn per item
    always @(posedge i_clk) begin : weight_driver
        bit busy;
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
            idle_cycles = 0;
        end else begin
            busy = drv_valid;
            if (drv_valid && in_ch.ready) begin
                skin_weight(drv_w);
                n_taken++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (weight_q.size() > 0 && idle_cycles >= weight_q[0].gap &&
                    (!weight_q[0].drain || vertex_q.size() == 0)) begin
                    drv_w     <= weight_q[0].w;
                    drv_valid <= 1'b1;
                    void'(weight_q.pop_front());
                    idle_cycles = 0;
                end else begin
                    drv_valid <= 1'b0;
                    idle_cycles++;
                end
            end
        end
    end

    // receiver: stalls per vertex, with stretches of no stall
    always @(posedge i_clk) begin : vertex_monitor
        t_vertex want;
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
            stall_left = $urandom_range(0, 12);
        end else if (out_ch.valid && sink_ready) begin
            if (vertex_q.size() == 0) begin
                $display("%0t unexpected vertex: actual %0d %0d %0d", $time,
                         out_ch.vertex_x, out_ch.vertex_y, out_ch.vertex_z);
                errors++;
            end else begin
                want = vertex_q.pop_front();
                check_field("vertex_x", want.x, out_ch.vertex_x);
                check_field("vertex_y", want.y, out_ch.vertex_y);
                check_field("vertex_z", want.z, out_ch.vertex_z);
            end
            vertices_seen++;
            if (vertices_seen % 16 == 0)
                no_stall = ($urandom_range(0, 2) == 0);
            stall_left = no_stall ? 0 : $urandom_range(0, 12);
            sink_ready <= (stall_left == 0);
        end else if (!sink_ready) begin
            if (stall_left <= 1) begin
                stall_left = 0;
                sink_ready <= 1'b1;
            end else begin
                stall_left--;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((drv_valid && in_ch.ready) || (out_ch.valid && sink_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t watchdog: no transaction for %0d cycles", $time, quiet_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        int nw;
        int k;
        int bias_left;
        bit noisy;
        bit drain_next;
        real qa, qb, qc, qd, mag;
        t_in_item w;

        // plain cases: identity, quarter turn about z, half turn about x
        add_weight('{ONE, 2 * ONE, 3 * ONE, 16'sd0, 16'sd0, 16'sd0, Q_ONE,
                     ONE, -ONE, 32'sd0, BIAS_ONE, 1'b1}, 1'b0);
        add_weight('{32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd23170, 16'sd23170,
                     ONE, 32'sd0, 32'sd0, BIAS_ONE, 1'b1}, 1'b0);
        add_weight('{32'sd0, 32'sd0, 32'sd0, Q_ONE, 16'sd0, 16'sd0, 16'sd0,
                     ONE, ONE, ONE, BIAS_ONE, 1'b1}, 1'b0);
        // zero bias on extreme data
        add_weight('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
                     32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 17'd0, 1'b1}, 1'b0);
        // two half weights
        add_weight('{ONE, ONE, ONE, 16'sd0, 16'sd0, 16'sd0, Q_ONE,
                     ONE, 32'sd0, -ONE, 17'd32768, 1'b0}, 1'b0);
        add_weight('{-ONE, 32'sd0, ONE, 16'sd0, Q_ONE, 16'sd0, 16'sd0,
                     ONE, ONE, 32'sd0, 17'd32768, 1'b1}, 1'b0);
        // running sum driven past the positive 32-bit output range
        for (k = 0; k < 5; k++)
            add_weight('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, Q_ONE, Q_ONE, Q_ONE,
                         Q_ONE, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, BIAS_MAX,
                         k == 4}, 1'b0);
        // and past the negative one
        for (k = 0; k < 5; k++)
            add_weight('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 16'sd0, 16'sd0,
                         16'sd0, Q_ONE, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                         BIAS_MAX, k == 4}, 1'b0);
        // non-unit quaternion at the negative extreme
        add_weight('{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, 16'sh8000, 16'sh8000, 16'sh8000,
                     16'sh8000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, BIAS_ONE,
                     1'b1}, 1'b0);
        // smallest nonzero bias, mixed signs
        add_weight('{32'sh7fff_ffff, 32'sh8000_0000, ONE, 16'sh8000, Q_ONE, -16'sd1, 16'sd1,
                     32'sh8000_0000, 32'sh7fff_ffff, 32'sd1, 17'd1, 1'b1}, 1'b0);
        // one weight whose vertex leaves the 32-bit range without hitting the sum bound
        add_weight('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 16'sd0, 16'sd0, 16'sd0,
                     Q_ONE, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, BIAS_ONE, 1'b1},
                   1'b0);

        // random vertices: mostly unit rotations with biases summing to one
        drain_next = 1'b1;
        while (weight_q.size() < WEIGHT_ITEMS) begin
            calm  = ($urandom_range(0, 3) == 0);
            noisy = ($urandom_range(0, 7) == 0);
            nw = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
            bias_left = 65536;
            for (k = 0; k < nw; k++) begin
                w.joint_pos_x = pos_val(noisy);
                w.joint_pos_y = pos_val(noisy);
                w.joint_pos_z = pos_val(noisy);
                w.offset_x    = pos_val(noisy);
                w.offset_y    = pos_val(noisy);
                w.offset_z    = pos_val(noisy);
                if (noisy || $urandom_range(0, 4) == 0) begin
                    w.orient_x = Q_W'($urandom);
                    w.orient_y = Q_W'($urandom);
                    w.orient_z = Q_W'($urandom);
                    w.orient_w = Q_W'($urandom);
                end else begin
                    qa  = $urandom_range(0, 20000) / 10000.0 - 1.0;
                    qb  = $urandom_range(0, 20000) / 10000.0 - 1.0;
                    qc  = $urandom_range(0, 20000) / 10000.0 - 1.0;
                    qd  = $urandom_range(0, 20000) / 10000.0 - 1.0;
                    mag = $sqrt(qa * qa + qb * qb + qc * qc + qd * qd);
                    if (mag < 0.01) begin
                        qa  = 0.0;
                        qb  = 0.0;
                        qc  = 0.0;
                        qd  = 1.0;
                        mag = 1.0;
                    end
                    w.orient_x = Q_W'($rtoi(qa / mag * 32767.0));
                    w.orient_y = Q_W'($rtoi(qb / mag * 32767.0));
                    w.orient_z = Q_W'($rtoi(qc / mag * 32767.0));
                    w.orient_w = Q_W'($rtoi(qd / mag * 32767.0));
                end
                if (noisy) begin
                    w.bias = BIAS_W'($urandom_range(0, 131071));
                end else if (k == nw - 1) begin
                    w.bias = BIAS_W'(bias_left);
                end else begin
                    w.bias = BIAS_W'($urandom_range(0, bias_left));
                    bias_left -= int'(w.bias);
                end
                w.last_weight = (k == nw - 1);
                add_weight(w, drain_next && k == 0);
            end
            drain_next = ($urandom_range(0, 99) == 0);
        end
        n_total = weight_q.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_taken < n_total || vertex_q.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
